FILE: rtl/lfrf_pkg.sv
// ----------------------------------------------------------------------------
// Longest free run finder package
// Shared constants, sequencer states and the run tracker command word.
// ----------------------------------------------------------------------------
package lfrf_pkg;

    localparam int unsigned FIELD_W      = 10;
    localparam int unsigned MAX_SLOTS_DEF = 512;
    localparam logic [FIELD_W-1:0] WINDOW_LENGTH_RST = 10'd480;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } lfrf_state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic free_slot;
        logic flush;
    } lfrf_trk_cmd_t;

endpackage

FILE: rtl/longest_free_run_finder_unit.sv
// ----------------------------------------------------------------------------
// Longest free run finder
// Marks busy ranges in a slot bitmap and reports the longest free run.
// ----------------------------------------------------------------------------
// Operation: a word with a range marks its slots busy from start up to the clipped
// end, one slot per cycle through the bitmap write port; a closing word then
// scans the bitmap through the read port, flushes the tracker and loads the result.
// Throughput: one word at a time; s_ready is low while a word is in work.
// Reset: every slot of the bitmap is swept to free with s_ready low;
// window_length returns to 480.
// ----------------------------------------------------------------------------
module longest_free_run_finder_unit
    import lfrf_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_range_valid,
    input  logic [FIELD_W-1:0] s_range_start,
    input  logic [FIELD_W-1:0] s_range_end,
    input  logic               s_last_in_set,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_gap_start,
    output logic [FIELD_W-1:0] m_gap_length
);

    localparam int unsigned AW = $clog2(MAX_SLOTS);
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
    localparam int unsigned ZW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int unsigned SW = ZW + 1;
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_SLOTS - 1);

    lfrf_state_t        state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      mark_idx_reg, mark_idx_next;
    logic [CW-1:0]      mark_end_reg, mark_end_next;
    logic               last_reg, last_next;
    logic               p_vld_reg, p_vld_next;
    logic [AW-1:0]      p_idx_reg, p_idx_next;
    logic [FIELD_W-1:0] window_length_reg;
    logic               m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0] gap_start_reg, gap_length_reg;

    logic [ZW-1:0] wl_z, hi_z, lo_z, w_z, hi_clip_z, bs_z, bl_z;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] mark_inc;
    logic          do_mark;
    logic          out_load;

    logic          mem_wr_en, mem_wr_data, mem_rd_en, mem_rd_data;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;

    lfrf_trk_cmd_t trk_cmd;
    logic [CW-1:0] trk_best_start, trk_best_len;

    assign wl_z      = ZW'(window_length_reg);
    assign w_eff     = CW'((wl_z > ZW'(MAX_SLOTS)) ? ZW'(MAX_SLOTS) : wl_z);
    assign w_z       = ZW'(w_eff);
    assign hi_z      = ZW'(s_range_end);
    assign lo_z      = ZW'(s_range_start);
    assign hi_clip_z = (hi_z > w_z) ? w_z : hi_z;
    assign do_mark   = s_range_valid && (lo_z < hi_clip_z);
    assign mark_inc  = mark_idx_reg + 1'b1;
    assign bs_z      = ZW'(trk_best_start);
    assign bl_z      = ZW'(trk_best_len);

    lfrf_bitmap #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lfrf_run_track #(
        .AW (AW),
        .CW (CW)
    ) u_run_track (
        .aclk       (aclk),
        .cmd        (trk_cmd),
        .idx        (p_idx_reg),
        .window     (w_eff),
        .best_start (trk_best_start),
        .best_len   (trk_best_len)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mark_idx_next = mark_idx_reg;
        mark_end_next = mark_end_reg;
        last_next     = last_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = p_idx_reg;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = p_idx_reg;
        mem_wr_data   = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = cnt_reg[AW-1:0];
        trk_cmd       = '0;
        trk_cmd.step      = p_vld_reg;
        trk_cmd.free_slot = !mem_rd_data;
        mem_wr_en         = p_vld_reg;

        case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg[AW-1:0];
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mark_idx_next = CW'(lo_z);
                    mark_end_next = CW'(hi_clip_z);
                    last_next     = s_last_in_set;
                    if (do_mark) begin
                        state_next = ST_MARK;
                    end else if (s_last_in_set) begin
                        trk_cmd.start = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_MARK: begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = mark_idx_reg[AW-1:0];
                mem_wr_data   = 1'b1;
                mark_idx_next = mark_inc;
                if (mark_inc == mark_end_reg) begin
                    if (last_reg) begin
                        trk_cmd.start = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                mem_rd_en  = (cnt_reg != MAX_CNT);
                p_vld_next = mem_rd_en;
                p_idx_next = cnt_reg[AW-1:0];
                if (mem_rd_en) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                trk_cmd.flush = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            cnt_reg           <= '0;
            p_vld_reg         <= 1'b0;
            m_valid_reg       <= 1'b0;
            window_length_reg <= WINDOW_LENGTH_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            p_vld_reg   <= p_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                window_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mark_idx_reg <= mark_idx_next;
        mark_end_reg <= mark_end_next;
        last_reg     <= last_next;
        p_idx_reg    <= p_idx_next;
        if (out_load) begin
            gap_start_reg  <= bs_z[FIELD_W-1:0];
            gap_length_reg <= bl_z[FIELD_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_gap_start  = gap_start_reg;
    assign m_gap_length = gap_length_reg;

    a_clear_after_reset: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready
    ) else $error("word accepted during bitmap sweep");

    a_mark_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |-> (mark_idx_reg < mark_end_reg)
    ) else $error("mark pointer past range end");

    a_run_in_window: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |->
            (SW'(trk_best_start) + SW'(trk_best_len) <= SW'(w_eff))
    ) else $error("reported run leaves the window");

endmodule

FILE: rtl/lfrf_bitmap.sv
// ----------------------------------------------------------------------------
// Occupancy bitmap
// One write port and one registered read port over the slot bits.
// ----------------------------------------------------------------------------
module lfrf_bitmap
    import lfrf_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_SLOTS_DEF,
    parameter int unsigned AW    = $clog2(MAX_SLOTS_DEF)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lfrf_run_track.sv
// ----------------------------------------------------------------------------
// Run tracker
// Follows the current free run one slot per step and keeps the longest one.
// ----------------------------------------------------------------------------
module lfrf_run_track
    import lfrf_pkg::*;
#(
    parameter int unsigned AW = $clog2(MAX_SLOTS_DEF),
    parameter int unsigned CW = $clog2(MAX_SLOTS_DEF + 1)
) (
    input  logic          aclk,
    input  lfrf_trk_cmd_t cmd,
    input  logic [AW-1:0] idx,
    input  logic [CW-1:0] window,
    output logic [CW-1:0] best_start,
    output logic [CW-1:0] best_len
);

    logic [AW-1:0] run_start_reg, run_start_next;
    logic [CW-1:0] run_len_reg, run_len_next;
    logic [CW-1:0] best_start_reg, best_start_next;
    logic [CW-1:0] best_len_reg, best_len_next;
    logic          longer;
    logic          in_run;

    assign longer = run_len_reg > best_len_reg;
    assign in_run = cmd.free_slot && (CW'(idx) < window);

    always_comb begin
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        if (cmd.start) begin
            run_len_next    = '0;
            best_len_next   = '0;
            best_start_next = window;
        end else if (cmd.step && in_run) begin
            if (run_len_reg == '0) begin
                run_start_next = idx;
            end
            run_len_next = run_len_reg + 1'b1;
        end else if (cmd.step || cmd.flush) begin
            if (longer) begin
                best_len_next   = run_len_reg;
                best_start_next = CW'(run_start_reg);
            end
            run_len_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
    end

    assign best_start = best_start_reg;
    assign best_len   = best_len_reg;

endmodule

FILE: test/lfrf_gap_checker.sv
// ----------------------------------------------------------------------------
// Longest free run checker
// Tracks the slot bitmap and window length from the accepted words and
// register writes, predicts the gap of every closing word and compares it
// field by field with the result words in order.
// ----------------------------------------------------------------------------
module lfrf_gap_checker
    import lfrf_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_range_valid,
    input  logic [FIELD_W-1:0] s_range_start,
    input  logic [FIELD_W-1:0] s_range_end,
    input  logic               s_last_in_set,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [FIELD_W-1:0] m_gap_start,
    input  logic [FIELD_W-1:0] m_gap_length,
    output int                 fail_count,
    output int                 pending_gaps,
    output int                 gaps_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
    } gap_t;

    gap_t               expected_gaps[$];
    bit                 slot_busy [0:MAX_SLOTS];
    logic [FIELD_W-1:0] window_length;

    function automatic int effective_window();
        return (window_length > MAX_SLOTS) ? MAX_SLOTS : int'(window_length);
    endfunction

    function automatic void mark_busy(input int lo, input int hi);
        int w;
        w = effective_window();
        if (hi > w) begin
            hi = w;
        end
        for (int i = lo; i < hi; i++) begin
            slot_busy[i] = 1'b1;
        end
    endfunction

    function automatic gap_t longest_gap();
        int   w;
        int   run_start;
        int   run_len;
        int   best_start;
        int   best_len;
        gap_t g;
        w          = effective_window();
        run_start  = 0;
        run_len    = 0;
        best_start = w;
        best_len   = 0;
        for (int i = 0; i < w; i++) begin
            if (!slot_busy[i]) begin
                if (run_len == 0) begin
                    run_start = i;
                end
                run_len++;
            end else begin
                if (run_len > best_len) begin
                    best_len   = run_len;
                    best_start = run_start;
                end
                run_len = 0;
            end
        end
        if (run_len > best_len) begin
            best_len   = run_len;
            best_start = run_start;
        end
        g.start = best_start[FIELD_W-1:0];
        g.len   = best_len[FIELD_W-1:0];
        return g;
    endfunction

    task automatic report_error(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        gap_t got;
        gap_t want;
        if (!aresetn) begin
            window_length = WINDOW_LENGTH_RST;
            for (int i = 0; i <= MAX_SLOTS; i++) begin
                slot_busy[i] = 1'b0;
            end
            expected_gaps.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.start = m_gap_start;
                got.len   = m_gap_length;
                if (expected_gaps.size() == 0) begin
                    report_error($sformatf("unexpected gap word start %0d length %0d",
                                           got.start, got.len));
                end else begin
                    want = expected_gaps.pop_front();
                    gaps_checked++;
                    if (got.start !== want.start) begin
                        report_error($sformatf("gap_start got %0d want %0d",
                                               got.start, want.start));
                    end
                    if (got.len !== want.len) begin
                        report_error($sformatf("gap_length got %0d want %0d",
                                               got.len, want.len));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_range_valid) begin
                    mark_busy(int'(s_range_start), int'(s_range_end));
                end
                if (s_last_in_set) begin
                    expected_gaps.push_back(longest_gap());
                    for (int i = 0; i <= MAX_SLOTS; i++) begin
                        slot_busy[i] = 1'b0;
                    end
                end
            end
            if (cfg_wr_en) begin
                window_length = cfg_wr_data;
            end
        end
        pending_gaps = expected_gaps.size();
    end

endmodule

FILE: test/tb_longest_free_run_finder_unit.sv
// ----------------------------------------------------------------------------
// Longest free run finder testbench
// Drives directed and random sets of busy ranges under a range of window
// lengths, with random idle cycles on both channels and one long result
// stall, and leaves prediction and comparison to the gap checker.
// ----------------------------------------------------------------------------
module tb_longest_free_run_finder_unit
    import lfrf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SLOTS     = MAX_SLOTS_DEF;
    localparam int          RANDOM_WORDS  = 1100;
    localparam int          IDLE_PCT      = 29;
    localparam int          HOLD_CYCLES   = 3000;
    localparam int          SETTLE_CYCLES = 2 * MAX_SLOTS + 64;
    localparam int          STALL_LIMIT   = 20000;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [FIELD_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_range_valid;
    logic [FIELD_W-1:0] s_range_start;
    logic [FIELD_W-1:0] s_range_end;
    logic               s_last_in_set;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_gap_start;
    logic [FIELD_W-1:0] m_gap_length;

    int                 fail_count;
    int                 pending_gaps;
    int                 gaps_checked;

    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 hold_req;
    bit                 open_set;
    logic [FIELD_W-1:0] window_now;
    int                 words_sent;
    int                 sets_closed;
    int                 window_writes;
    int                 directed_words;
    int                 stall_cycles;
    int                 phase;

    longest_free_run_finder_unit #(
        .MAX_SLOTS(MAX_SLOTS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_range_valid(s_range_valid),
        .s_range_start(s_range_start),
        .s_range_end  (s_range_end),
        .s_last_in_set(s_last_in_set),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gap_start  (m_gap_start),
        .m_gap_length (m_gap_length)
    );

    lfrf_gap_checker #(
        .MAX_SLOTS(MAX_SLOTS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_range_valid(s_range_valid),
        .s_range_start(s_range_start),
        .s_range_end  (s_range_end),
        .s_last_in_set(s_last_in_set),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gap_start  (m_gap_start),
        .m_gap_length (m_gap_length),
        .fail_count   (fail_count),
        .pending_gaps (pending_gaps),
        .gaps_checked (gaps_checked)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_word(input bit rv, input logic [FIELD_W-1:0] lo,
                             input logic [FIELD_W-1:0] hi, input bit last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_range_valid <= rv;
        s_range_start <= lo;
        s_range_end   <= hi;
        s_last_in_set <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
        if (last) begin
            sets_closed++;
        end
        open_set = !last;
    endtask

    task automatic write_window(input logic [FIELD_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_gaps != 0) @(negedge aclk);
        // let a marking word still in work finish
        repeat (open_set ? SETTLE_CYCLES : 4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en  <= 1'b0;
        window_now = value;
        window_writes++;
    endtask

    task automatic send_random_set();
        int                 we;
        int                 n;
        int                 r;
        bit                 rv;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        we = (window_now > MAX_SLOTS) ? MAX_SLOTS : int'(window_now);
        n  = $urandom_range(0, 6);
        for (int i = 0; i <= n; i++) begin
            r  = $urandom_range(99);
            rv = ($urandom_range(19) != 0);
            if (r < 6) begin
                lo = FIELD_W'($urandom_range(0, 1023));
                hi = FIELD_W'($urandom_range(0, 1023));
                rv = 1'($urandom_range(1));
            end else if (r < 14) begin
                lo = FIELD_W'($urandom_range(0, we));
                hi = FIELD_W'($urandom_range(0, int'(lo)));
            end else begin
                lo = FIELD_W'($urandom_range(0, we));
                hi = FIELD_W'(lo + $urandom_range(0, we / 4 + 2));
            end
            send_word(rv, lo, hi, i == n);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_range_valid = 1'b0;
        s_range_start = '0;
        s_range_end   = '0;
        s_last_in_set = 1'b0;
        tx_idle_pct   = IDLE_PCT;
        rx_idle_pct   = IDLE_PCT;
        window_now    = WINDOW_LENGTH_RST;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty set, full window, all-ones fields on a closing word without range
        send_word(1'b0, 10'd0, 10'd0, 1'b1);
        send_word(1'b1, 10'd0, 10'd480, 1'b0);
        send_word(1'b0, 10'h3FF, 10'h3FF, 1'b1);
        send_word(1'b1, 10'h3FF, 10'h3FF, 1'b1);
        send_word(1'b1, 10'd0, 10'h3FF, 1'b1);
        // tie between two runs, then a reversed range
        send_word(1'b1, 10'd0, 10'd100, 1'b0);
        send_word(1'b1, 10'd200, 10'd380, 1'b1);
        send_word(1'b1, 10'd300, 10'd200, 1'b1);
        send_word(1'b1, 10'd5, 10'd6, 1'b0);
        send_word(1'b1, 10'd479, 10'd480, 1'b1);
        write_window(10'd0);
        send_word(1'b1, 10'd0, 10'd10, 1'b1);
        write_window(10'h3FF);
        send_word(1'b1, 10'd511, 10'd512, 1'b1);
        write_window(10'd1);
        send_word(1'b1, 10'd0, 10'd1, 1'b1);
        send_word(1'b0, 10'd0, 10'd0, 1'b1);
        write_window(10'd512);
        send_word(1'b1, 10'd1, 10'd511, 1'b1);
        // shrink the window in the middle of a set
        send_word(1'b1, 10'd0, 10'd10, 1'b0);
        send_word(1'b1, 10'd500, 10'd512, 1'b0);
        write_window(10'd300);
        send_word(1'b0, 10'd0, 10'd0, 1'b1);
        send_word(1'b0, 10'd0, 10'd0, 1'b1);
        write_window(10'd512);
        send_word(1'b0, 10'd0, 10'd0, 1'b1);
        directed_words = words_sent;

        phase = 0;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            case ($urandom_range(9))
                0: write_window(10'd0);
                1: write_window(10'd512);
                2: write_window(FIELD_W'($urandom_range(513, 1023)));
                3: write_window(FIELD_W'($urandom_range(1, 8)));
                default: write_window(FIELD_W'($urandom_range(1, 512)));
            endcase
            tx_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            rx_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            repeat ($urandom_range(8, 24)) send_random_set();
            phase++;
        end

        s_valid <= 1'b0;
        while (pending_gaps != 0) @(negedge aclk);
        repeat (2 * MAX_SLOTS) @(negedge aclk);
        $display("Sent %0d words (%0d directed) in %0d sets over %0d window settings",
                 words_sent, directed_words, sets_closed, window_writes);
        $display("Checked %0d gap results, with a %0d-cycle result stall",
                 gaps_checked, HOLD_CYCLES);
        if (fail_count == 0 && pending_gaps == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lfrf_pkg.sv
rtl/lfrf_bitmap.sv
rtl/lfrf_run_track.sv
rtl/longest_free_run_finder_unit.sv
test/lfrf_gap_checker.sv
test/tb_longest_free_run_finder_unit.sv
